@@ rtl/hrpr_pkg.sv @@
// ----------------------------------------------------------------------------
// hrpr_pkg: shared types and constants for the haze removal recovery core
// Pixel and factor widths, pipeline depths, register indexes, divider stage.
// ----------------------------------------------------------------------------
package hrpr_pkg;

    localparam int PIX_W            = 8;
    localparam int FACTOR_W         = 16;
    localparam int FACTOR_FRAC_BITS = 16;
    localparam int FACTOR_CAP       = (9 * (2 ** FACTOR_FRAC_BITS)) / 10;
    localparam int PROD_W           = FACTOR_W + PIX_W;
    localparam int NUM_LANES        = 3;
    localparam int DIV_BITS         = PIX_W;
    // multiply, divider setup, one stage per quotient bit, clamp
    localparam int LANE_STAGES      = DIV_BITS + 3;
    // input register and the two ambient stages
    localparam int PRE_STAGES       = 3;
    localparam int TOTAL_LATENCY    = PRE_STAGES + LANE_STAGES + 1;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = FACTOR_W;

    localparam logic [FACTOR_W-1:0] HAZE_FACTOR_RST = FACTOR_W'(58982);
    localparam logic [PIX_W-1:0]    ATMOS_LIGHT_RST = PIX_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAZE_FACTOR = 2'd0,
        CFG_ATMOS_LIGHT = 2'd1
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [NUM_LANES-1:0][PIX_W-1:0] t_pix_vec;

    // one stage of the restoring divider and the flags riding along with it
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] quo;
        logic [PIX_W-1:0] div;
        logic             sat;
        logic             spec;
        logic             hot;
    } t_div_stage;

endpackage

@@ rtl/hrpr_ambient.sv @@
// ----------------------------------------------------------------------------
// hrpr_ambient: ambient level of one pixel
// Scales the local mean by the capped factor, takes the darkest channel and
// keeps the smaller of the two. Two register stages; channels travel along.
// ----------------------------------------------------------------------------
module hrpr_ambient
    import hrpr_pkg::*;
(
    input  logic                i_clk,
    input  logic [FACTOR_W-1:0] i_haze_factor,
    input  t_pix_vec            i_chan,
    input  t_pix                i_mean,
    output t_pix                o_amb,
    output t_pix_vec            o_chan
);

    logic [FACTOR_W-1:0] f_capped;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_shr;
    t_pix                n_scaled;
    t_pix                n_dark;

    t_pix     r_scaled;
    t_pix     r_dark;
    t_pix_vec r_chan_a;
    t_pix     r_amb;
    t_pix_vec r_chan_b;

    always_comb begin
        if (32'(i_haze_factor) > 32'(FACTOR_CAP)) begin
            f_capped = FACTOR_W'(FACTOR_CAP);
        end else begin
            f_capped = i_haze_factor;
        end
        prod     = PROD_W'(f_capped) * PROD_W'(i_mean);
        prod_shr = prod >> FACTOR_FRAC_BITS;
        n_scaled = prod_shr[PIX_W-1:0];
        n_dark   = i_chan[0];
        for (int k = 1; k < NUM_LANES; k++) begin
            if (i_chan[k] < n_dark) begin
                n_dark = i_chan[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_dark   <= n_dark;
        r_chan_a <= i_chan;
        r_amb    <= (r_scaled < r_dark) ? r_scaled : r_dark;
        r_chan_b <= r_chan_a;
    end

    assign o_amb  = r_amb;
    assign o_chan = r_chan_b;

endmodule

@@ rtl/hrpr_lane.sv @@
// ----------------------------------------------------------------------------
// hrpr_lane: recovery of one color channel
// Forms (c - amb) * A, then divides by (A - amb) in a restoring divider with
// one quotient bit per stage, and clamps to the pixel range (0 or full when amb >= A).
// ----------------------------------------------------------------------------
module hrpr_lane
    import hrpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_pix i_chan,
    input  t_pix i_amb,
    input  t_pix i_atmos,
    output logic o_vld,
    output t_pix o_res
);

    function automatic t_div_stage div_step(input t_div_stage st);
        logic [PIX_W:0] t;
        t_div_stage     s;
        s     = st;
        t     = {st.rem, st.low[PIX_W-1]};
        s.low = st.low << 1;
        if (t >= {1'b0, st.div}) begin
            s.rem = PIX_W'(t - {1'b0, st.div});
            s.quo = {st.quo[PIX_W-2:0], 1'b1};
        end else begin
            s.rem = t[PIX_W-1:0];
            s.quo = {st.quo[PIX_W-2:0], 1'b0};
        end
        return s;
    endfunction

    logic [2*PIX_W-1:0] r_num;
    t_pix               r_den;
    logic               r_spec;
    logic               r_hot;
    t_div_stage         r_div [DIV_BITS+1];
    t_pix               r_res;
    t_pix               n_res;
    logic [LANE_STAGES-1:0] r_vld;
    t_div_stage         n_div0;

    always_comb begin
        n_div0.rem  = r_num[2*PIX_W-1:PIX_W];
        n_div0.low  = r_num[PIX_W-1:0];
        n_div0.quo  = '0;
        n_div0.div  = r_den;
        // quotient would need more than one pixel's bits
        n_div0.sat  = r_num >= {r_den, {PIX_W{1'b0}}};
        n_div0.spec = r_spec;
        n_div0.hot  = r_hot;
    end

    always_comb begin
        priority if (r_div[DIV_BITS].spec) begin
            n_res = r_div[DIV_BITS].hot ? '1 : '0;
        end else if (r_div[DIV_BITS].sat) begin
            n_res = '1;
        end else begin
            n_res = r_div[DIV_BITS].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= (2*PIX_W)'(i_chan - i_amb) * (2*PIX_W)'(i_atmos);
        r_den  <= i_atmos - i_amb;
        r_spec <= i_amb >= i_atmos;
        r_hot  <= i_chan > i_amb;
        r_div[0] <= n_div0;
        for (int k = 0; k < DIV_BITS; k++) begin
            r_div[k+1] <= div_step(r_div[k]);
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_STAGES-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[LANE_STAGES-1];
    assign o_res = r_res;

`ifndef SYNTHESIS
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !r_div[0].sat && !r_div[0].spec |-> r_div[0].rem < r_div[0].div)
        else $error("divider entered with remainder not below divisor");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_BITS+1] && !r_div[DIV_BITS].sat && !r_div[DIV_BITS].spec
        |-> r_div[DIV_BITS].rem < r_div[DIV_BITS].div)
        else $error("divider left a remainder not below divisor");

    a_spec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_BITS+1] && r_div[DIV_BITS].spec |=> (r_res == '0 || r_res == '1))
        else $error("ambient at or above light gave a level other than 0 or full");
`endif

endmodule

@@ rtl/haze_removal_pixel_recovery_core.sv @@
// ----------------------------------------------------------------------------
// haze_removal_pixel_recovery_core: per-pixel haze removal, recovery stage
// Usage:
//   Raise start with a pixel (red, green, blue) and its local dark-channel
//   mean; the request is taken at each rising edge with start high and busy
//   low. Busy is high during reset and is cleared by the first clock edge
//   after it, then stays low, so one pixel can enter every clock.
//   Each result (three recovered channels and the ambient level) appears on
//   the outputs for one cycle with o_strobe high, in request order.
//   Throughput is one pixel per clock. A request passes the input register,
//   the ambient and multiply stages, the divider setup, the eight-stage
//   divider in each channel lane, the clamp and the output register.
//   The receiver cannot stall: results must be taken as they come.
//   Configuration: i_cfg_we with i_cfg_idx 0 writes the haze factor (Q0.16,
//   capped at 0.9), index 1 the atmospheric light. Write only while no
//   request is in flight.
//   Reset (synchronous, active low) drops all requests in flight, holds busy
//   high until the first edge after reset, and restores factor 0.9 and
//   light 255.
// ----------------------------------------------------------------------------
module haze_removal_pixel_recovery_core
    import hrpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_local_mean_in,
    output logic [PIX_W-1:0]      o_red_out,
    output logic [PIX_W-1:0]      o_green_out,
    output logic [PIX_W-1:0]      o_blue_out,
    output logic [PIX_W-1:0]      o_ambient_out,
    output logic                  o_strobe
);

    logic                  r_busy;
    logic [FACTOR_W-1:0]   r_haze_factor;
    t_pix                  r_atmos_light;
    logic [PRE_STAGES-1:0] r_vld_pre;
    t_pix_vec              r_in_chan;
    t_pix                  r_in_mean;
    t_pix                  amb;
    t_pix_vec              amb_chan;
    t_pix                  r_amb_dly [LANE_STAGES];
    logic [NUM_LANES-1:0]  lane_vld;
    t_pix_vec              lane_res;
    t_pix_vec              r_out_chan;
    t_pix                  r_out_amb;
    logic                  r_strobe;
    logic                  accept;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_haze_factor <= HAZE_FACTOR_RST;
            r_atmos_light <= ATMOS_LIGHT_RST;
            r_vld_pre     <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HAZE_FACTOR: r_haze_factor <= i_cfg_data[FACTOR_W-1:0];
                    CFG_ATMOS_LIGHT: r_atmos_light <= i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            r_vld_pre <= {r_vld_pre[PRE_STAGES-2:0], accept};
            r_strobe  <= lane_vld[0];
        end
    end

    // payload: capture the request, delay ambient to meet the lanes, merge
    always_ff @(posedge i_clk) begin
        r_in_chan    <= {i_blue_in, i_green_in, i_red_in};
        r_in_mean    <= i_local_mean_in;
        r_amb_dly[0] <= amb;
        for (int k = 1; k < LANE_STAGES; k++) begin
            r_amb_dly[k] <= r_amb_dly[k-1];
        end
        r_out_chan <= lane_res;
        r_out_amb  <= r_amb_dly[LANE_STAGES-1];
    end

    hrpr_ambient u_ambient (
        .i_clk         (i_clk),
        .i_haze_factor (r_haze_factor),
        .i_chan        (r_in_chan),
        .i_mean        (r_in_mean),
        .o_amb         (amb),
        .o_chan        (amb_chan)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        hrpr_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_vld_pre[PRE_STAGES-1]),
            .i_chan  (amb_chan[g]),
            .i_amb   (amb),
            .i_atmos (r_atmos_light),
            .o_vld   (lane_vld[g]),
            .o_res   (lane_res[g])
        );
    end

    assign busy          = r_busy;
    assign o_red_out     = r_out_chan[0];
    assign o_green_out   = r_out_chan[1];
    assign o_blue_out    = r_out_chan[2];
    assign o_ambient_out = r_out_amb;
    assign o_strobe      = r_strobe;

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy high outside reset");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_vld == '0 || lane_vld == '1)
        else $error("channel lanes out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##TOTAL_LATENCY o_strobe)
        else $error("request did not produce a result at the expected cycle");
`endif

endmodule

@@ dv/hrpr_recovery_checker.sv @@
// ----------------------------------------------------------------------------
// hrpr_recovery_checker: scoreboard for the haze removal recovery core
// Watches the request, configuration and result ports, predicts each
// recovered pixel from its own copy of the factor and light registers and
// compares every strobed result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module hrpr_recovery_checker
    import hrpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_red_in,
    input  logic [PIX_W-1:0]      i_green_in,
    input  logic [PIX_W-1:0]      i_blue_in,
    input  logic [PIX_W-1:0]      i_local_mean_in,
    input  logic [PIX_W-1:0]      i_red_out,
    input  logic [PIX_W-1:0]      i_green_out,
    input  logic [PIX_W-1:0]      i_blue_out,
    input  logic [PIX_W-1:0]      i_ambient_out,
    input  logic                  i_strobe,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // 0.9 in the factor's fixed-point format, truncated
    localparam logic [FACTOR_W-1:0] HAZE_CAP =
        FACTOR_W'((9 * (1 << FACTOR_FRAC_BITS)) / 10);
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] ambient;
    } t_recovered_px;

    logic [FACTOR_W-1:0] factor_cfg = HAZE_FACTOR_RST;
    logic [PIX_W-1:0]    light_cfg  = ATMOS_LIGHT_RST;
    t_recovered_px       expected_px_q[$];
    int                  fails   = 0;
    int                  checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    function automatic logic [PIX_W-1:0] recover_lane(
        input logic [PIX_W-1:0] chan,
        input logic [PIX_W-1:0] amb,
        input logic [PIX_W-1:0] light
    );
        logic [2*PIX_W-1:0] num;
        logic [2*PIX_W-1:0] quo;
        // ambient at or above the light: hard threshold on the channel
        if (amb >= light) begin
            return (chan > amb) ? PIX_MAX : '0;
        end
        num = (2*PIX_W)'(chan - amb) * light;
        quo = num / (2*PIX_W)'(light - amb);
        return (quo > PIX_MAX) ? PIX_MAX : quo[PIX_W-1:0];
    endfunction

    function automatic t_recovered_px recover_pixel(
        input logic [PIX_W-1:0] red,
        input logic [PIX_W-1:0] green,
        input logic [PIX_W-1:0] blue,
        input logic [PIX_W-1:0] mean
    );
        logic [FACTOR_W-1:0]       factor;
        logic [FACTOR_W+PIX_W-1:0] prod;
        logic [PIX_W-1:0]          scaled;
        logic [PIX_W-1:0]          dark;
        t_recovered_px             px;
        factor = (factor_cfg > HAZE_CAP) ? HAZE_CAP : factor_cfg;
        prod   = (FACTOR_W+PIX_W)'(factor) * mean;
        scaled = PIX_W'(prod >> FACTOR_FRAC_BITS);
        dark   = (red < green) ? red : green;
        dark   = (blue < dark) ? blue : dark;
        px.ambient = (scaled < dark) ? scaled : dark;
        px.red     = recover_lane(red, px.ambient, light_cfg);
        px.green   = recover_lane(green, px.ambient, light_cfg);
        px.blue    = recover_lane(blue, px.ambient, light_cfg);
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_recovered_px want;
        if (!i_rst_n) begin
            factor_cfg = HAZE_FACTOR_RST;
            light_cfg  = ATMOS_LIGHT_RST;
        end else begin
            if (i_strobe) begin
                if (expected_px_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fails = fails + 1;
                end else begin
                    want    = expected_px_q.pop_front();
                    checked = checked + 1;
                    if (i_red_out !== want.red) begin
                        $error("red_out: expected %0d, actual %0d", want.red, i_red_out);
                        fails = fails + 1;
                    end
                    if (i_green_out !== want.green) begin
                        $error("green_out: expected %0d, actual %0d",
                               want.green, i_green_out);
                        fails = fails + 1;
                    end
                    if (i_blue_out !== want.blue) begin
                        $error("blue_out: expected %0d, actual %0d", want.blue, i_blue_out);
                        fails = fails + 1;
                    end
                    if (i_ambient_out !== want.ambient) begin
                        $error("ambient_out: expected %0d, actual %0d",
                               want.ambient, i_ambient_out);
                        fails = fails + 1;
                    end
                end
            end
            if (start && !busy) begin
                want = recover_pixel(i_red_in, i_green_in, i_blue_in, i_local_mean_in);
                expected_px_q = {expected_px_q, want};
            end
            // registers take effect after any request at the same edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HAZE_FACTOR: factor_cfg = i_cfg_data[FACTOR_W-1:0];
                    CFG_ATMOS_LIGHT: light_cfg  = i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_px_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the haze removal recovery core
// Drives directed and random pixel requests under a series of factor and
// light settings, with random idle gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import hrpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
    localparam int RANDOM_PHASES   = 9;
    localparam int PIXELS_PER_PHASE = 72;
    localparam int DRAIN_LIMIT     = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic [PIX_W-1:0]      i_red_in;
    logic [PIX_W-1:0]      i_green_in;
    logic [PIX_W-1:0]      i_blue_in;
    logic [PIX_W-1:0]      i_local_mean_in;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic [PIX_W-1:0]      o_ambient_out;
    logic                  o_strobe;

    int fail_count;
    int pending;
    int checked;
    int pixels_sent  = 0;
    int settings_run = 1;
    bit no_idle      = 0;

    haze_removal_pixel_recovery_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_local_mean_in (i_local_mean_in),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_ambient_out   (o_ambient_out),
        .o_strobe        (o_strobe)
    );

    hrpr_recovery_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .i_local_mean_in (i_local_mean_in),
        .i_red_out       (o_red_out),
        .i_green_out     (o_green_out),
        .i_blue_out      (o_blue_out),
        .i_ambient_out   (o_ambient_out),
        .i_strobe        (o_strobe),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_pixel(
        input logic [PIX_W-1:0] red,
        input logic [PIX_W-1:0] green,
        input logic [PIX_W-1:0] blue,
        input logic [PIX_W-1:0] mean
    );
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 29) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_red_in        <= red;
        i_green_in      <= green;
        i_blue_in       <= blue;
        i_local_mean_in <= mean;
        // hold the request until an edge sees busy low
        do @(posedge i_clk); while (busy);
        pixels_sent++;
    endtask

    task automatic set_config(
        input logic [FACTOR_W-1:0] factor,
        input logic [PIX_W-1:0]    light
    );
        logic [CFG_DATA_W-1:0] word;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HAZE_FACTOR;
        i_cfg_data <= factor;
        @(posedge i_clk);
        // junk in the upper bits must be dropped by the 8-bit light register
        word = CFG_DATA_W'($urandom);
        word[PIX_W-1:0] = light;
        i_cfg_idx  <= CFG_ATMOS_LIGHT;
        i_cfg_data <= word;
        @(posedge i_clk);
        i_cfg_idx  <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [PIX_W-1:0] pick_level();
        int draw;
        draw = $urandom_range(0, 15);
        if (draw == 0) return '0;
        if (draw == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [PIX_W-1:0] near_level(input logic [PIX_W-1:0] base);
        int lvl;
        lvl = int'(base) + $urandom_range(0, 40);
        return (lvl > 255) ? '1 : PIX_W'(lvl);
    endfunction

    task automatic send_random_pixel();
        logic [PIX_W-1:0] base;
        base = pick_level();
        // hazy pixels: channels close together so the ambient level matters
        if ($urandom_range(0, 9) < 4) begin
            send_pixel(near_level(base), near_level(base), near_level(base), pick_level());
        end else begin
            send_pixel(pick_level(), pick_level(), pick_level(), pick_level());
        end
    endtask

    initial begin
        int waited;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_HAZE_FACTOR;
        i_cfg_data      <= '0;
        i_red_in        <= '0;
        i_green_in      <= '0;
        i_blue_in       <= '0;
        i_local_mean_in <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: factor 0.9, light 255
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd255);
        send_pixel(8'd200, 8'd210, 8'd220, 8'd255);
        send_pixel(8'd255, 8'd250, 8'd240, 8'd100);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd0);
        send_pixel(8'd128, 8'd64, 8'd32, 8'd200);
        send_pixel(8'd85, 8'd170, 8'd255, 8'd170);
        send_pixel(8'd255, 8'd255, 8'd254, 8'd255);

        // zero light: every channel thresholds against the ambient level
        set_config(16'hFFFF, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd1, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd255);

        // capped factor, ambient above a low light, quotient saturation
        set_config(16'hFFFF, 8'd100);
        send_pixel(8'd255, 8'd240, 8'd230, 8'd255);
        send_pixel(8'd230, 8'd229, 8'd250, 8'd255);
        send_pixel(8'd90, 8'd200, 8'd150, 8'd50);

        set_config(16'd58983, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(16'd0, 8'd255);
                1: set_config(16'hFFFF, 8'd255);
                2: set_config(16'd58983, 8'd1);
                3: set_config(16'd58982, 8'd0);
                4: set_config(16'd1, 8'd128);
                5: set_config(16'd32768, PIX_W'($urandom));
                default: set_config(FACTOR_W'($urandom), PIX_W'($urandom_range(1, 255)));
            endcase
            // one phase back to back with no idle cycles at all
            no_idle = (phase == 4);
            repeat (PIXELS_PER_PHASE) send_random_pixel();
        end
        no_idle = 0;

        start <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TOTAL_LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d pixel requests under %0d factor/light settings, %0d results checked",
                 pixels_sent, settings_run, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
